// File: design/rkd_pkg.sv
// Package for the region key derivation and block decryption design.
// Holds the request and response types, register indexes and AES-128 round functions.
// No dependencies.
`default_nettype none
package rkd_pkg;

   localparam int BLOCKS_PER_REGION_DEF = 64;
   localparam int REGION_COUNT_DEF      = 8;

   localparam logic [1:0] CSR_KEYGEN_HI = 2'd0;
   localparam logic [1:0] CSR_KEYGEN_LO = 2'd1;
   localparam logic [1:0] CSR_SEED_HI   = 2'd2;
   localparam logic [1:0] CSR_SEED_LO   = 2'd3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_NOKEY = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  region_sel;
      logic [63:0] cipher_hi;
      logic [63:0] cipher_lo;
   } req_type;

   typedef struct packed {
      logic [63:0] plain_hi;
      logic [63:0] plain_lo;
      logic [5:0]  block_number;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic decrypt;
   } core_cmd_type;

   typedef logic [7:0] sbox_table_type [0:255];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic sbox_table_type invert_table(input sbox_table_type fwd);
      sbox_table_type inv;
      for (int i = 0; i < 256; i++) begin
         inv[fwd[i]] = 8'(i);
      end
      return inv;
   endfunction

   localparam sbox_table_type INV_SBOX = invert_table(SBOX);

   typedef logic [7:0] rcon_table_type [0:9];
   localparam rcon_table_type RCON = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
      return v[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
      return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
   endfunction

   function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] n0, n1, n2, n3;
      n0 = k[127:96] ^ sub_rot(k[31:0], rc);
      n1 = k[95:64] ^ n0;
      n2 = k[63:32] ^ n1;
      n3 = k[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] p0, p1, p2, p3;
      p3 = k[31:0] ^ k[63:32];
      p2 = k[63:32] ^ k[95:64];
      p1 = k[95:64] ^ k[127:96];
      p0 = k[127:96] ^ sub_rot(p3, rc);
      return {p0, p1, p2, p3};
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = INV_SBOX[get_byte(s, r + 4 * c)];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4 * c);
         a1 = get_byte(s, 4 * c + 1);
         a2 = get_byte(s, 4 * c + 2);
         a3 = get_byte(s, 4 * c + 3);
         t[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic logic [7:0] gm9(input logic [7:0] a);
      return xtime(xtime(xtime(a))) ^ a;
   endfunction

   function automatic logic [7:0] gm11(input logic [7:0] a);
      return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
   endfunction

   function automatic logic [7:0] gm13(input logic [7:0] a);
      return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
   endfunction

   function automatic logic [7:0] gm14(input logic [7:0] a);
      return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4 * c);
         a1 = get_byte(s, 4 * c + 1);
         a2 = get_byte(s, 4 * c + 2);
         a3 = get_byte(s, 4 * c + 3);
         t[127 - 32 * c -: 8] = gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3);
         t[119 - 32 * c -: 8] = gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3);
         t[111 - 32 * c -: 8] = gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3);
         t[103 - 32 * c -: 8] = gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// File: design/rkd_aes_core.sv
// Iterative AES-128 round unit: one round per cycle with on-the-fly key schedule.
// Encrypts from the cipher key or decrypts from the last round key. Depends on rkd_pkg.
`default_nettype none
module rkd_aes_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rkd_pkg::core_cmd_type cmd,
   input  wire logic [127:0]         key,
   input  wire logic [127:0]         blk,
   output logic                      done,
   output logic [127:0]              blk_out,
   output logic [127:0]              key_out
);
   import rkd_pkg::*;

   localparam logic [3:0] LAST_ROUND = 4'd10;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic         dec_ff, dec_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] rk_ff, rk_in;
   logic [3:0]   rc_sel;
   logic [127:0] rk_step;
   logic [127:0] st_step;

   always_comb begin
      rc_sel  = dec_ff ? 4'(LAST_ROUND - rnd_ff) : 4'(rnd_ff - 4'd1);
      if (dec_ff) begin
         rk_step = key_inv(rk_ff, RCON[rc_sel]);
         st_step = inv_sub_shift(st_ff) ^ rk_step;
         if (rnd_ff != LAST_ROUND) begin
            st_step = inv_mix(st_step);
         end
      end else begin
         rk_step = key_fwd(rk_ff, RCON[rc_sel]);
         st_step = sub_shift(st_ff);
         if (rnd_ff != LAST_ROUND) begin
            st_step = mix(st_step);
         end
         st_step = st_step ^ rk_step;
      end

      busy_in = busy_ff;
      done_in = done_ff;
      dec_in  = dec_ff;
      rnd_in  = rnd_ff;
      st_in   = st_ff;
      rk_in   = rk_ff;
      if (busy_ff) begin
         st_in  = st_step;
         rk_in  = rk_step;
         rnd_in = rnd_ff + 4'd1;
         if (rnd_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         dec_in  = cmd.decrypt;
         rnd_in  = 4'd1;
         st_in   = blk ^ key;
         rk_in   = key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dec_ff <= dec_in;
      rnd_ff <= rnd_in;
      st_ff  <= st_in;
      rk_ff  <= rk_in;
   end

   assign done    = done_ff;
   assign blk_out = st_ff;
   assign key_out = rk_ff;

endmodule
`default_nettype wire

// File: design/region_key_derive_block_decrypt.sv
// Top level: request sequencer, key store, block counter and response register.
// Depends on rkd_pkg and rkd_aes_core.
//
// A start request for region r runs r+2 passes of the shared AES round unit: r+1
// encryptions of the seed under the key-generation key, then one key expansion of the
// derived key to obtain its last round key. A data request is decrypted in the round
// unit and the result is registered into the response register; a data request sent
// before any start answers with the no-key status. The request side stalls while a
// request is being worked on; the response register lets the next request enter while
// a response still waits.
`default_nettype none
module region_key_derive_block_decrypt #(
   parameter int BLOCKS_PER_REGION = rkd_pkg::BLOCKS_PER_REGION_DEF,
   parameter int REGION_COUNT      = rkd_pkg::REGION_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rkd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rkd_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [63:0]      csr_wdata
);
   import rkd_pkg::*;

   localparam int CNT_W = (BLOCKS_PER_REGION > 1) ? $clog2(BLOCKS_PER_REGION) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DERIVE = 2'd1;
   localparam logic [1:0] S_EXPAND = 2'd2;
   localparam logic [1:0] S_PUSH   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [63:0]      kg_hi_ff, kg_lo_ff, seed_hi_ff, seed_lo_ff;
   logic [127:0]     dkey_ff, dkey_in;
   logic             ready_ff, ready_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       region_ff, region_in;
   logic [2:0]       iter_ff, iter_in;
   logic             nokey_ff, nokey_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             pushed_ok;
   logic [2:0]       region_mod;
   logic [8:0]       reg_work;
   logic [7:0]       cnt8;
   core_cmd_type     cmd;
   logic [127:0]     core_key, core_blk;
   logic             core_done;
   logic [127:0]     core_blk_out, core_key_out;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign pushed_ok = !rsp_valid_ff || !rsp_stall;
   assign cnt8      = 8'(cnt_ff);

   always_comb begin
      reg_work = {6'd0, req_data.region_sel};
      for (int i = 0; i < 8; i++) begin
         if (reg_work >= 9'(REGION_COUNT)) begin
            reg_work = reg_work - 9'(REGION_COUNT);
         end
      end
      region_mod = reg_work[2:0];
   end

   rkd_aes_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .key     (core_key),
      .blk     (core_blk),
      .done    (core_done),
      .blk_out (core_blk_out),
      .key_out (core_key_out)
   );

   always_comb begin
      state_in     = state_ff;
      dkey_in      = dkey_ff;
      ready_in     = ready_ff;
      cnt_in       = cnt_ff;
      region_in    = region_ff;
      iter_in      = iter_ff;
      nokey_in     = nokey_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd          = '0;
      core_key     = {kg_hi_ff, kg_lo_ff};
      core_blk     = {seed_hi_ff, seed_lo_ff};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_START) begin
                  cmd.start = 1'b1;
                  region_in = region_mod;
                  iter_in   = 3'd0;
                  state_in  = S_DERIVE;
               end else if (ready_ff) begin
                  cmd.start   = 1'b1;
                  cmd.decrypt = 1'b1;
                  core_key    = dkey_ff;
                  core_blk    = {req_data.cipher_hi, req_data.cipher_lo};
                  nokey_in    = 1'b0;
                  state_in    = S_PUSH;
               end else begin
                  nokey_in = 1'b1;
                  state_in = S_PUSH;
               end
            end
         end
         S_DERIVE: begin
            if (core_done) begin
               cmd.start = 1'b1;
               core_blk  = core_blk_out;
               if (iter_ff == region_ff) begin
                  core_key = core_blk_out;
                  state_in = S_EXPAND;
               end else begin
                  iter_in = iter_ff + 3'd1;
               end
            end
         end
         S_EXPAND: begin
            if (core_done) begin
               dkey_in  = core_key_out;
               ready_in = 1'b1;
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_PUSH: begin
            if ((nokey_ff || core_done) && pushed_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (nokey_ff) begin
                  rsp_in.plain_hi     = '0;
                  rsp_in.plain_lo     = '0;
                  rsp_in.block_number = '0;
                  rsp_in.status       = ST_NOKEY;
               end else begin
                  rsp_in.plain_hi     = core_blk_out[127:64] ^ {cnt8, 56'd0};
                  rsp_in.plain_lo     = core_blk_out[63:0];
                  rsp_in.block_number = 6'(cnt_ff);
                  rsp_in.status       = ST_OK;
                  cnt_in = (cnt_ff == CNT_W'(BLOCKS_PER_REGION - 1)) ? '0 : cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         cnt_ff       <= '0;
         dkey_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         nokey_ff     <= 1'b0;
         kg_hi_ff     <= '0;
         kg_lo_ff     <= '0;
         seed_hi_ff   <= '0;
         seed_lo_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         cnt_ff       <= cnt_in;
         dkey_ff      <= dkey_in;
         rsp_valid_ff <= rsp_valid_in;
         nokey_ff     <= nokey_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KEYGEN_HI: kg_hi_ff   <= csr_wdata;
               CSR_KEYGEN_LO: kg_lo_ff   <= csr_wdata;
               CSR_SEED_HI:   seed_hi_ff <= csr_wdata;
               CSR_SEED_LO:   seed_lo_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      region_ff <= region_in;
      iter_ff   <= iter_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: design/rkd_checker.sv
// Port-level checker for the region key derivation and block decryption top level.
// Depends on rkd_pkg; bound to region_key_derive_block_decrypt at the end of this file.
`default_nettype none
module rkd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rkd_pkg::rsp_type rsp_data
);
   import rkd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   a_nokey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_NOKEY) |->
         rsp_data.plain_hi == 64'd0 && rsp_data.plain_lo == 64'd0 &&
         rsp_data.block_number == 6'd0)
      else $error("No-key response carries data.");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Request side not stalled after a request.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind region_key_derive_block_decrypt rkd_checker u_rkd_checker (.*);
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for region_key_derive_block_decrypt: region key derivation
// and AES-128 block decryption, checked against an in-bench AES predictor.
// Depends on rkd_pkg and the design files.
`default_nettype none

class decrypt_scoreboard;
   rkd_pkg::rsp_type pending[$];
   int errors;
   logic [127:0] keygen_key;
   logic [127:0] seed;
   logic [127:0] region_key;
   logic [5:0] counter;
   logic key_ready;
   logic [7:0] fwd[256];
   logic [7:0] inv[256];
   logic [7:0] rc[10];

   function new();
      logic [7:0] tmp[256];
      tmp = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,
         8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,
         8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,
         8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
         8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,
         8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
         8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,8'hd0,8'hef,
         8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,
         8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,
         8'h64,8'h5d,8'h19,8'h73,8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,
         8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
         8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,
         8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,8'hba,8'h78,8'h25,8'h2e,
         8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,
         8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,
         8'h28,8'hdf,8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
         8'hb0,8'h54,8'hbb,8'h16};
      fwd = tmp;
      for (int i = 0; i < 256; i++) inv[fwd[i]] = 8'(i);
      rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      errors = 0;
      keygen_key = '0;
      seed = '0;
      region_key = '0;
      counter = '0;
      key_ready = 1'b0;
   endfunction

   function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function void round_keys(logic [127:0] k, output logic [7:0] rk[176]);
      logic [7:0] t[4];
      logic [7:0] f;
      for (int i = 0; i < 16; i++) rk[i] = k[127 - 8 * i -: 8];
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) t[j] = rk[4 * (i - 1) + j];
         if (i % 4 == 0) begin
            f = t[0];
            t[0] = fwd[t[1]] ^ rc[i / 4 - 1];
            t[1] = fwd[t[2]];
            t[2] = fwd[t[3]];
            t[3] = fwd[f];
         end
         for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 4) + j] ^ t[j];
      end
   endfunction

   function logic [127:0] encrypt(logic [7:0] rk[176], logic [127:0] v);
      logic [7:0] s[16], t[16], a[4];
      for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8] ^ rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) t[r + 4 * c] = fwd[s[r + 4 * ((c + r) % 4)]];
         for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) a[j] = t[4 * c + j];
            if (rnd < 10) begin
               for (int j = 0; j < 4; j++)
                  s[4 * c + j] = gf_mul(a[j], 8'd2) ^ gf_mul(a[(j + 1) % 4], 8'd3)
                                 ^ a[(j + 2) % 4] ^ a[(j + 3) % 4];
            end else begin
               for (int j = 0; j < 4; j++) s[4 * c + j] = a[j];
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[16 * rnd + i];
      end
      for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
      return v;
   endfunction

   function logic [127:0] decrypt(logic [7:0] rk[176], logic [127:0] v);
      logic [7:0] s[16], t[16], a[4];
      for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8] ^ rk[160 + i];
      for (int rnd = 9; rnd >= 0; rnd--) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) t[r + 4 * ((c + r) % 4)] = inv[s[r + 4 * c]];
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16 * rnd + i];
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++) begin
               for (int j = 0; j < 4; j++) a[j] = s[4 * c + j];
               for (int j = 0; j < 4; j++)
                  s[4 * c + j] = gf_mul(a[j], 8'd14) ^ gf_mul(a[(j + 1) % 4], 8'd11)
                                 ^ gf_mul(a[(j + 2) % 4], 8'd13)
                                 ^ gf_mul(a[(j + 3) % 4], 8'd9);
            end
         end
      end
      for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
      return v;
   endfunction

   function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
         rkd_pkg::CSR_KEYGEN_HI: keygen_key[127:64] = val;
         rkd_pkg::CSR_KEYGEN_LO: keygen_key[63:0] = val;
         rkd_pkg::CSR_SEED_HI: seed[127:64] = val;
         default: seed[63:0] = val;
      endcase
   endfunction

   function void note_request(rkd_pkg::req_type r);
      logic [7:0] rk[176];
      logic [127:0] v;
      rkd_pkg::rsp_type e;
      if (r.opcode == rkd_pkg::OP_START) begin
         round_keys(keygen_key, rk);
         v = seed;
         for (int i = 0; i <= int'(r.region_sel); i++) v = encrypt(rk, v);
         region_key = v;
         counter = '0;
         key_ready = 1'b1;
      end else if (!key_ready) begin
         e = '0;
         e.status = rkd_pkg::ST_NOKEY;
         pending.push_back(e);
      end else begin
         round_keys(region_key, rk);
         v = decrypt(rk, {r.cipher_hi, r.cipher_lo});
         v[127:120] ^= {2'b00, counter};
         e.plain_hi = v[127:64];
         e.plain_lo = v[63:0];
         e.block_number = counter;
         e.status = rkd_pkg::ST_OK;
         pending.push_back(e);
         counter = counter + 6'd1;
      end
   endfunction

   function void check_response(rkd_pkg::rsp_type got, realtime now);
      rkd_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", now, got);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.plain_hi !== e.plain_hi || got.plain_lo !== e.plain_lo) begin
         $display("%0t: plaintext expected %h_%h actual %h_%h", now,
                  e.plain_hi, e.plain_lo, got.plain_hi, got.plain_lo);
         errors++;
      end
      if (got.block_number !== e.block_number) begin
         $display("%0t: block_number expected %0d actual %0d", now,
                  e.block_number, got.block_number);
         errors++;
      end
      if (got.status !== e.status) begin
         $display("%0t: status expected %0d actual %0d", now, e.status, got.status);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rkd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_KEYGEN_HI;
   logic [63:0] csr_wdata = '0;

   decrypt_scoreboard decrypt_sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp = 1'b0;
   longint cycles = 0;

   region_key_derive_block_decrypt dut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data), .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) decrypt_sb.check_response(rsp_data, $realtime);
         if (req_valid && !req_stall) decrypt_sb.note_request(req_data);
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_request(logic op, logic [2:0] region, logic [127:0] cipher);
      do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      req_valid <= 1'b1;
      req_data <= '{opcode: op, region_sel: region, cipher_hi: cipher[127:64],
                    cipher_lo: cipher[63:0]};
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (decrypt_sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      decrypt_sb.write_reg(idx, val);
   endtask

   task automatic write_all(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
      write_csr(CSR_KEYGEN_HI, a);
      write_csr(CSR_KEYGEN_LO, b);
      write_csr(CSR_SEED_HI, c);
      write_csr(CSR_SEED_LO, d);
      csr_we <= 1'b0;
   endtask

   task automatic random_stream(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 4) begin
            send_request(OP_START, 3'($urandom_range(7)), {rand64(), rand64()});
         end else begin
            send_request(OP_DATA, 3'($urandom()), {rand64(), rand64()});
         end
         n++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(OP_DATA, 3'd7, {64'hffffffffffffffff, 64'hffffffffffffffff});
      send_request(OP_DATA, 3'd0, '0);
      drain();
      send_request(OP_START, 3'd0, '0);
      send_request(OP_DATA, 3'd0, '0);
      send_request(OP_DATA, 3'd0, {128{1'b1}});
      drain();
      write_all(64'hffffffffffffffff, 64'hffffffffffffffff,
                64'hffffffffffffffff, 64'hffffffffffffffff);
      send_request(OP_DATA, 3'd0, 128'h1);
      send_request(OP_START, 3'd7, '0);
      send_request(OP_DATA, 3'd0, {64'h8000000000000000, 64'h0});
      drain();
      write_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h0011223344556677, 64'h8899aabbccddeeff);
      send_request(OP_START, 3'd3, '0);
      send_request(OP_START, 3'd1, '0);
      for (int i = 0; i < 6; i++) send_request(OP_DATA, 3'(i), {rand64(), rand64()});
      drain();
      send_idle_pct = 23;
      recv_idle_pct = 79;
      random_stream(560);
      drain();
      write_all(rand64(), rand64(), rand64(), rand64());
      send_request(OP_START, 3'd5, '0);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_stream(10);
      join
      drain();
      send_idle_pct = 79;
      recv_idle_pct = 23;
      random_stream(480);
      drain();
      write_all(rand64(), rand64(), rand64(), rand64());
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(OP_START, 3'($urandom_range(7)), '0);
      random_stream(580);
      drain();
      if (decrypt_sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
design/rkd_pkg.sv
design/rkd_aes_core.sv
design/region_key_derive_block_decrypt.sv
design/rkd_checker.sv
bench/tb.sv
